### rtl/ucf_pkg.sv
// ----------------------------------------------------------------------------
// ucf_pkg
// shared types, constants and decode helpers for the utf-8 new code point
// filter
// ----------------------------------------------------------------------------
package ucf_pkg;

    // seen bitmap geometry (word width is a power of two)
    localparam int SEEN_WORD_WIDTH = 64;
    localparam int CP_SPACE_INT    = 32'h0011_0000;
    localparam int SEEN_DEPTH      = (CP_SPACE_INT + SEEN_WORD_WIDTH - 1) / SEEN_WORD_WIDTH;
    localparam int BIT_W           = $clog2(SEEN_WORD_WIDTH);
    localparam int ADDR_W          = $clog2(SEEN_DEPTH);

    localparam logic [20:0] CP_LIMIT = 21'h11_0000;
    localparam logic [20:0] CP_MIN   = 21'h00_0080;

    // lead byte ranges
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] LEAD2_MAX = 8'hdf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD3_MAX = 8'hef;
    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD4_MAX = 8'hf4;

    // special leads that narrow the second byte
    localparam logic [7:0] LEAD_E0   = 8'he0;
    localparam logic [7:0] LEAD_ED   = 8'hed;
    localparam logic [7:0] LEAD_F0   = 8'hf0;
    localparam logic [7:0] LEAD_F4   = 8'hf4;
    localparam logic [7:0] CONT_A0   = 8'ha0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // input kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [SEEN_WORD_WIDTH-1:0] seen_word_t;
    typedef logic [BIT_W-1:0]           bit_idx_t;

    // decoded code point from the front end
    typedef struct packed {
        logic        done;
        logic [20:0] cp;
        logic [2:0]  len;
    } dec_t;

    // lookup stage result toward the output register
    typedef struct packed {
        logic        fresh;
        logic [20:0] cp;
        logic [2:0]  len;
    } res_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if (b >= LEAD2_MIN && b <= LEAD2_MAX)
        begin
            len = LEN_2;
        end
        else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
        begin
            len = LEN_3;
        end
        else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
        begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [20:0] assemble(input logic [31:0] v, input logic [2:0] len);
        logic [20:0] cp;
        unique case (len)
            LEN_2:   cp = {10'b0, v[12:8], v[5:0]};
            LEN_3:   cp = {5'b0, v[19:16], v[13:8], v[5:0]};
            default: cp = {v[26:24], v[21:16], v[13:8], v[5:0]};
        endcase
        return cp;
    endfunction

endpackage

### rtl/ucf_decoder.sv
// ----------------------------------------------------------------------------
// ucf_decoder
// strict utf-8 front end: holds the pending sequence, flags completed
// code points
// ----------------------------------------------------------------------------
module ucf_decoder
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic           clear,
    input  logic [7:0]     data_byte,
    input  logic           end_of_text,
    output ucf_pkg::dec_t  dec
);

    logic [23:0] pend_bytes_reg, pend_bytes_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [2:0]  exp_len_reg, exp_len_next;

    logic [7:0]  lead;
    logic        cont_ok;
    logic        narrow_bad;
    logic [2:0]  new_len;
    logic [2:0]  cnt_inc;
    logic [20:0] cp_full;

    assign lead    = pend_bytes_reg[7:0];
    assign new_len = ucf_pkg::lead_len(data_byte);
    assign cnt_inc = {1'b0, pend_cnt_reg} + 3'd1;
    assign cp_full = ucf_pkg::assemble({pend_bytes_reg, data_byte}, exp_len_reg);

    // second byte limits for overlong, surrogate and above-range forms
    assign narrow_bad = (pend_cnt_reg == 2'd1) &&
        ((lead == ucf_pkg::LEAD_E0 && data_byte <  ucf_pkg::CONT_A0) ||
         (lead == ucf_pkg::LEAD_ED && data_byte >= ucf_pkg::CONT_A0) ||
         (lead == ucf_pkg::LEAD_F0 && data_byte <  ucf_pkg::CONT_90) ||
         (lead == ucf_pkg::LEAD_F4 && data_byte >= ucf_pkg::CONT_90));

    assign cont_ok = ((data_byte & ucf_pkg::CONT_MASK) == ucf_pkg::CONT_TAG) && !narrow_bad;

    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        exp_len_next    = exp_len_reg;
        dec.done        = 1'b0;
        dec.cp          = cp_full;
        dec.len         = exp_len_reg;

        if (exp_len_reg == ucf_pkg::LEN_NONE || !cont_ok)
        begin
            // idle or broken sequence: retry this byte as a lead
            if (new_len != ucf_pkg::LEN_NONE)
            begin
                pend_bytes_next = {16'b0, data_byte};
                pend_cnt_next   = 2'd1;
                exp_len_next    = new_len;
            end
            else
            begin
                pend_bytes_next = '0;
                pend_cnt_next   = '0;
                exp_len_next    = ucf_pkg::LEN_NONE;
            end
        end
        else if (cnt_inc >= exp_len_reg)
        begin
            pend_bytes_next = '0;
            pend_cnt_next   = '0;
            exp_len_next    = ucf_pkg::LEN_NONE;
            dec.done        = (cp_full >= ucf_pkg::CP_MIN) && (cp_full < ucf_pkg::CP_LIMIT);
        end
        else
        begin
            pend_bytes_next = {pend_bytes_reg[15:0], data_byte};
            pend_cnt_next   = cnt_inc[1:0];
        end

        // incomplete sequence at end of text is dropped
        if (end_of_text)
        begin
            pend_bytes_next = '0;
            pend_cnt_next   = '0;
            exp_len_next    = ucf_pkg::LEN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bytes_reg <= '0;
            pend_cnt_reg   <= '0;
            exp_len_reg    <= ucf_pkg::LEN_NONE;
        end
        else if (clear)
        begin
            pend_bytes_reg <= '0;
            pend_cnt_reg   <= '0;
            exp_len_reg    <= ucf_pkg::LEN_NONE;
        end
        else if (take)
        begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
            exp_len_reg    <= exp_len_next;
        end
    end

endmodule

### rtl/ucf_seen_map.sv
// ----------------------------------------------------------------------------
// ucf_seen_map
// seen bitmap memory with lookup stage, read-modify-write, write forwarding
// and clearing pass
// ----------------------------------------------------------------------------
module ucf_seen_map
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           lookup,
    input  ucf_pkg::dec_t  dec,
    input  logic           clear_req,
    input  logic           out_free,
    output logic           busy,
    output logic           hold,
    output logic           res_go,
    output ucf_pkg::res_t  res
);

    ucf_pkg::seen_word_t mem [ucf_pkg::SEEN_DEPTH];
    ucf_pkg::seen_word_t rd_data_reg;

    logic                clearing_reg;
    ucf_pkg::addr_t      clr_cnt_reg;

    logic                s1_valid_reg;
    logic [20:0]         s1_cp_reg;
    logic [2:0]          s1_len_reg;

    logic                fwd_valid_reg;
    ucf_pkg::addr_t      fwd_addr_reg;
    ucf_pkg::seen_word_t fwd_data_reg;

    ucf_pkg::addr_t      rd_addr;
    ucf_pkg::addr_t      s1_addr;
    ucf_pkg::bit_idx_t   s1_bit;
    ucf_pkg::seen_word_t word_cur;
    ucf_pkg::seen_word_t mask;
    ucf_pkg::seen_word_t merged;
    logic                fresh;
    logic                s1_go;
    logic                s1_wr;

    logic                wr_en;
    ucf_pkg::addr_t      wr_addr;
    ucf_pkg::seen_word_t wr_data;

    assign rd_addr = ucf_pkg::addr_t'(dec.cp >> ucf_pkg::BIT_W);
    assign s1_addr = ucf_pkg::addr_t'(s1_cp_reg >> ucf_pkg::BIT_W);
    assign s1_bit  = s1_cp_reg[ucf_pkg::BIT_W-1:0];

    // newest write wins over the registered read
    assign word_cur = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rd_data_reg;
    assign mask     = ucf_pkg::seen_word_t'(1) << s1_bit;
    assign merged   = word_cur | mask;
    assign fresh    = (word_cur & mask) == '0;

    assign s1_go  = s1_valid_reg && out_free;
    assign s1_wr  = s1_go && fresh;
    assign hold   = s1_valid_reg && !out_free;
    assign busy   = clearing_reg;
    assign res_go = s1_wr;

    assign res.fresh = fresh;
    assign res.cp    = s1_cp_reg;
    assign res.len   = s1_len_reg;

    assign wr_en   = clearing_reg || s1_wr;
    assign wr_addr = clearing_reg ? clr_cnt_reg : s1_addr;
    assign wr_data = clearing_reg ? '0 : merged;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (lookup)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            s1_cp_reg  <= dec.cp;
            s1_len_reg <= dec.len;
        end
        if (s1_wr)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_req)
            begin
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (clearing_reg)
            begin
                if (clr_cnt_reg == ucf_pkg::addr_t'(ucf_pkg::SEEN_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                    clr_cnt_reg  <= '0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end

            if (lookup)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (clearing_reg || clear_req)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (s1_wr)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // lookup stage is empty for the whole clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !s1_valid_reg)
        else $error("lookup stage busy during clearing pass");

    // no lookup is issued while the bitmap is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) lookup |-> !clearing_reg)
        else $error("lookup issued during clearing pass");

    // a clear restarts the pass from the first word
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_req |=> (clearing_reg && clr_cnt_reg == '0))
        else $error("clear did not restart clearing pass");

    // a fresh code point sets exactly one more bit in its word
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_wr |-> ($countones(merged) == $countones(word_cur) + 1))
        else $error("bitmap update changed more than one bit");

endmodule

### rtl/ucf_out_reg.sv
// ----------------------------------------------------------------------------
// ucf_out_reg
// output register holding one result word until the consumer takes it
// ----------------------------------------------------------------------------
module ucf_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ucf_pkg::res_t  res,
    input  logic           out_stall,
    output logic           free,
    output logic           out_valid,
    output logic [20:0]    codepoint,
    output logic [2:0]     seq_length
);

    logic        valid_reg;
    logic [20:0] cp_reg;
    logic [2:0]  len_reg;

    assign free       = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign codepoint  = cp_reg;
    assign seq_length = len_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg  <= res.cp;
            len_reg <= res.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/utf8_new_codepoint_filter.sv
// ----------------------------------------------------------------------------
// utf8_new_codepoint_filter
// data path: a completing byte reads its bitmap word into the lookup stage;
//   a fresh result moves on to the output register once that is free
// throughput: one input word per cycle while in_stall is low, set by the
//   bitmap read-modify-write with forwarding of the last write
// reset and clear: a clearing pass over all SEEN_DEPTH (17408) words zeroes
//   the bitmap, one word a cycle; in_stall stays high for its length
// ----------------------------------------------------------------------------
module utf8_new_codepoint_filter
(
    input  logic        clk,
    input  logic        rst_n,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,

    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] codepoint,
    output logic [2:0]  seq_length
);

    logic          accept;
    logic          take;
    logic          clear;
    logic          lookup;
    logic          busy;
    logic          hold;
    logic          res_go;
    logic          out_free;
    ucf_pkg::dec_t dec;
    ucf_pkg::res_t res;

    // the input side stops only for the clearing pass or when the lookup
    // stage holds a word that the full output register cannot take
    assign in_stall = busy || hold;
    assign accept   = in_valid && !in_stall;

    // text bytes go through the decoder, clear words reset pending state
    // and kick off a new clearing pass
    assign take  = accept && (kind == ucf_pkg::KIND_BYTE);
    assign clear = accept && (kind == ucf_pkg::KIND_CLEAR);

    // only completed code points look up the bitmap
    assign lookup = take && dec.done;

    // utf-8 front end: pending sequence state and strict checks
    ucf_decoder u_decoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .clear       (clear),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .dec         (dec)
    );

    // seen bitmap: read on lookup, then tested and set if fresh once the output register is free
    ucf_seen_map u_seen_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup    (lookup),
        .dec       (dec),
        .clear_req (clear),
        .out_free  (out_free),
        .busy      (busy),
        .hold      (hold),
        .res_go    (res_go),
        .res       (res)
    );

    // output register parts the lookup stage from the consumer
    ucf_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_go),
        .res        (res),
        .out_stall  (out_stall),
        .free       (out_free),
        .out_valid  (out_valid),
        .codepoint  (codepoint),
        .seq_length (seq_length)
    );

endmodule

### verif/ucf_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_score_pkg
// scoreboard for the utf-8 new code point filter: a strict decoder with its
// own seen set predicts each fresh code point and checks the output words
// ----------------------------------------------------------------------------
package ucf_score_pkg;

    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
    } cp_rec_t;

    class codepoint_scoreboard;

        logic [23:0] held_bytes;
        int          held_count;
        logic [2:0]  want_len;
        bit          seen_cps[int];
        cp_rec_t     fresh_cps[$];
        int          errors;

        function new();
            drop_held();
            errors = 0;
        endfunction

        function void drop_held();
            held_bytes = '0;
            held_count = 0;
            want_len   = ucf_pkg::LEN_NONE;
        endfunction

        function logic [2:0] lead_length(logic [7:0] b);
            if (b >= ucf_pkg::LEAD2_MIN && b <= ucf_pkg::LEAD2_MAX)
            begin
                return ucf_pkg::LEN_2;
            end
            if (b >= ucf_pkg::LEAD3_MIN && b <= ucf_pkg::LEAD3_MAX)
            begin
                return ucf_pkg::LEN_3;
            end
            if (b >= ucf_pkg::LEAD4_MIN && b <= ucf_pkg::LEAD4_MAX)
            begin
                return ucf_pkg::LEN_4;
            end
            return ucf_pkg::LEN_NONE;
        endfunction

        // ascii and invalid leads leave the decoder idle
        function void start_lead(logic [7:0] b);
            logic [2:0] len;
            len = lead_length(b);
            drop_held();
            if (len != ucf_pkg::LEN_NONE)
            begin
                held_bytes = {16'h0, b};
                held_count = 1;
                want_len   = len;
            end
        endfunction

        function bit cont_fits(logic [7:0] b);
            logic [7:0] lead;
            lead = held_bytes[7:0];
            if ((b & ucf_pkg::CONT_MASK) != ucf_pkg::CONT_TAG)
            begin
                return 1'b0;
            end
            if (held_count == 1)
            begin
                if (lead == ucf_pkg::LEAD_E0 && b < ucf_pkg::CONT_A0)
                begin
                    return 1'b0;
                end
                if (lead == ucf_pkg::LEAD_ED && b >= ucf_pkg::CONT_A0)
                begin
                    return 1'b0;
                end
                if (lead == ucf_pkg::LEAD_F0 && b < ucf_pkg::CONT_90)
                begin
                    return 1'b0;
                end
                if (lead == ucf_pkg::LEAD_F4 && b >= ucf_pkg::CONT_90)
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // one accepted input word; queues the code point it makes, if fresh
        function void decode_word(logic k, logic [7:0] b, logic eot);
            logic [31:0] v;
            logic [20:0] cp;
            logic [2:0]  len;
            cp_rec_t     rec;
            if (k == ucf_pkg::KIND_CLEAR)
            begin
                drop_held();
                seen_cps.delete();
                return;
            end
            if (want_len == ucf_pkg::LEN_NONE || !cont_fits(b))
            begin
                start_lead(b);
            end
            else if (held_count + 1 >= int'(want_len))
            begin
                v   = {held_bytes, b};
                len = want_len;
                case (len)
                    ucf_pkg::LEN_2: cp = {10'b0, v[12:8], v[5:0]};
                    ucf_pkg::LEN_3: cp = {5'b0, v[19:16], v[13:8], v[5:0]};
                    default:        cp = {v[26:24], v[21:16], v[13:8], v[5:0]};
                endcase
                drop_held();
                if (cp >= ucf_pkg::CP_MIN && cp < ucf_pkg::CP_LIMIT &&
                    !seen_cps.exists(int'(cp)))
                begin
                    seen_cps[int'(cp)] = 1'b1;
                    rec.cp  = cp;
                    rec.len = len;
                    fresh_cps.insert(fresh_cps.size(), rec);
                end
            end
            else
            begin
                held_bytes = {held_bytes[15:0], b};
                held_count++;
            end
            if (eot)
            begin
                drop_held();
            end
        endfunction

        function int pending();
            return fresh_cps.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_codepoint(logic [20:0] cp, logic [2:0] len);
            cp_rec_t rec;
            if (fresh_cps.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word cp=%h len=%0d", cp, len));
                return;
            end
            rec = fresh_cps[0];
            fresh_cps.delete(0);
            if (cp !== rec.cp)
            begin
                report_mismatch($sformatf("codepoint %h, want %h", cp, rec.cp));
            end
            if (len !== rec.len)
            begin
                report_mismatch($sformatf("seq_length %0d, want %0d (cp %h)",
                                          len, rec.len, rec.cp));
            end
        endtask

    endclass

endpackage

### verif/utf8_new_codepoint_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_new_codepoint_filter_test
// drives byte streams through the strict utf-8 filter and checks that every
// fresh non-ascii code point comes out once, in order, with its length;
// directed edge cases first, then random strings under three idling phases
// ----------------------------------------------------------------------------
module utf8_new_codepoint_filter_test;

    // settle time after the drain, kept as margin to catch stray words
    localparam int SETTLE_CYCLES = 16;
    // drain limit covers a clearing pass of the bitmap plus slack
    localparam int DRAIN_LIMIT   = 200000;
    // long receiver hold-off so the block backs up into its input
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_BYTES   = 500;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        kind        = ucf_pkg::KIND_BYTE;
    logic [7:0]  data_byte   = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [20:0] codepoint;
    logic [2:0]  seq_length;

    ucf_score_pkg::codepoint_scoreboard sb = new();

    // idling odds in percent, set per phase by the stimulus
    int send_idle_pct = 31;
    int recv_idle_pct = 87;

    // hold-off request from the stimulus, counted down in the receiver
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // text bytes of one string, sent with end_of_text on the last one
    logic [7:0] text_q[$];

    // leads that narrow the range of the second byte
    logic [7:0]  narrow_leads[4]  = '{ucf_pkg::LEAD_E0, ucf_pkg::LEAD_ED,
                                      ucf_pkg::LEAD_F0, ucf_pkg::LEAD_F4};
    // code points at the edges of each encoding length and around surrogates
    logic [20:0] boundary_cps[8] = '{21'h000080, 21'h0007ff, 21'h000800, 21'h00d7ff,
                                     21'h00e000, 21'h00ffff, 21'h010000, 21'h10ffff};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_new_codepoint_filter i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .codepoint   (codepoint),
        .seq_length  (seq_length)
    );

    // ------------------------------------------------------------------------
    // receiver: check each accepted word, then pick the next stall value
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_codepoint(codepoint, seq_length);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_go && !hold_done)
        begin
            // one long hold-off while the sender keeps offering words
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sender: optional idle cycles, then hold the word until it is taken
    // ------------------------------------------------------------------------
    task automatic send_word(logic k, logic [7:0] b, logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            // payload is free to wander while valid is low
            in_valid    <= 1'b0;
            kind        <= 1'($urandom);
            data_byte   <= 8'($urandom);
            end_of_text <= 1'($urandom);
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        data_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        sb.decode_word(k, b, eot);
    endtask

    // clear word: data and end flag are don't-care, so randomize them
    task automatic send_clear();
        send_word(ucf_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
    endtask

    // send the queued string; rarely a clear lands in the middle of it
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
        begin
            if (i > 0 && $urandom_range(999) < 3)
            begin
                send_clear();
            end
            send_word(ucf_pkg::KIND_BYTE, text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    function automatic logic [2:0] cp_len(logic [20:0] cp);
        if (cp < 21'h000800)
        begin
            return ucf_pkg::LEN_2;
        end
        if (cp < 21'h010000)
        begin
            return ucf_pkg::LEN_3;
        end
        return ucf_pkg::LEN_4;
    endfunction

    // append the shortest encoding of a code point to the string
    function automatic void add_char(logic [20:0] cp);
        logic [2:0]  len;
        logic [31:0] v;
        int          i;
        len = cp_len(cp);
        case (len)
            ucf_pkg::LEN_2: v = {16'h0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            ucf_pkg::LEN_3: v = {8'h0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10,
                                 cp[5:0]};
            default:        v = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10,
                                 cp[11:6], 2'b10, cp[5:0]};
        endcase
        for (i = int'(len) - 1; i >= 0; i--)
        begin
            text_q.insert(text_q.size(), v[8*i +: 8]);
        end
    endfunction

    // mix of repeats from small sets and fresh values over the whole space
    function automatic logic [20:0] random_cp();
        logic [20:0] cp;
        case ($urandom_range(9))
            0, 1:    cp = boundary_cps[$urandom_range(7)];
            2, 3:    cp = 21'h000080 + 21'($urandom_range(47));
            4, 5:    cp = 21'($urandom_range(32'h0080, 32'h07ff));
            6, 7:
            begin
                cp = 21'($urandom_range(32'h0800, 32'hffff));
                // surrogates are not encodable, move them out of the way
                if (cp >= 21'h00d800 && cp <= 21'h00dfff)
                begin
                    cp ^= 21'h001000;
                end
            end
            default: cp = 21'($urandom_range(32'h010000, 32'h10ffff));
        endcase
        return cp;
    endfunction

    // random strings: mostly well-formed text, some ascii, some broken input
    task automatic random_text(int n_bytes);
        int         sent;
        int         chars;
        int         pick;
        int         n;
        int         i;
        int         j;
        logic [7:0] lead;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(99) < 3)
            begin
                send_clear();
            end
            chars = $urandom_range(1, 8);
            for (i = 0; i < chars; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    add_char(random_cp());
                end
                else if (pick < 78)
                begin
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
                end
                else if (pick < 90)
                begin
                    // narrowing lead with any continuation, valid or not
                    lead = narrow_leads[$urandom_range(3)];
                    text_q.insert(text_q.size(), lead);
                    n = (lead >= ucf_pkg::LEAD4_MIN) ? 3 : 2;
                    for (j = 0; j < n; j++)
                    begin
                        text_q.insert(text_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
                    end
                end
                else
                begin
                    // raw noise bytes
                    n = $urandom_range(1, 3);
                    for (j = 0; j < n; j++)
                    begin
                        text_q.insert(text_q.size(), 8'($urandom));
                    end
                end
            end
            // now and then cut the string so a sequence is left open at its end
            if (text_q.size() > 1 && $urandom_range(9) == 0)
            begin
                void'(text_q.pop_back());
            end
            sent += text_q.size();
            send_text();
        end
    endtask

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        int phase;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ascii extremes, no output
        text_q = '{8'h00, 8'h7f};
        send_text();
        // U+0080, overlong three-byte, surrogate, overlong four-byte,
        // above U+10FFFF, U+10FFFF, bad leads, bad continuation retried as lead
        text_q = '{8'hc2, 8'h80, 8'he0, 8'h9f, 8'hed, 8'ha0, 8'hf0, 8'h8f,
                   8'hf4, 8'h90, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hc1, 8'hff,
                   8'hc3, 8'hc3, 8'ha9};
        send_text();
        // sequence cut off by end of text is dropped
        text_q = '{8'he2, 8'h82};
        send_text();
        // already seen, nothing comes out
        text_q = '{8'hc2, 8'h80};
        send_text();
        // after a clear the same code point is fresh again
        send_clear();
        text_q = '{8'hc2, 8'h80};
        send_text();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go       = 1'b1;
                end
            endcase
            random_text(PHASE_BYTES);
        end

        in_valid <= 1'b0;

        // wait for every expected word, then a few cycles for strays
        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected words never arrived",
                                         sb.pending()));
        end

        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
